@@ rtl/sslew_pkg.sv @@
package sslew_pkg;

    // servo limits in degrees
    localparam logic [7:0] HEAD_MIN   = 8'd60;
    localparam logic [7:0] HEAD_MAX   = 8'd110;
    localparam logic [7:0] HAND_MIN   = 8'd90;
    localparam logic [7:0] HAND_MAX   = 8'd133;
    localparam logic [7:0] ANGLE_MAX  = 8'd180;
    localparam logic [7:0] POS_RESET  = 8'd90;
    localparam logic [7:0] RAMP_STEP  = 8'd2;

    // servo select codes
    localparam logic SERVO_HEAD = 1'b0;
    localparam logic SERVO_HAND = 1'b1;

    // pulse width: 500 + angle*2000/180, i.e. 500 + floor(angle*728200 / 2^16)
    localparam logic [11:0] PULSE_BASE  = 12'd500;
    localparam logic [19:0] PULSE_RECIP = 20'd728200;

    typedef struct packed {
        logic load;        // capture a new request
        logic emit_step;   // write a ramp set-point to the output register
        logic emit_final;  // write the exact target and update the position
    } sslew_cmd_t;

    typedef struct packed {
        logic enable;      // configuration register
        logic ramp_more;   // another ramp set-point is due
        logic slot_free;   // output register empty or being taken this cycle
    } sslew_status_t;

endpackage

@@ rtl/sslew_ctrl.sv @@
module sslew_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  sslew_pkg::sslew_status_t status,
    output sslew_pkg::sslew_cmd_t    cmd
);
    import sslew_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RAMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.emit_step  = 1'b0;
        cmd.emit_final = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // disabled requests are taken and dropped
                if (s_tvalid && status.enable)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP:
            begin
                if (status.slot_free)
                begin
                    if (status.ramp_more)
                    begin
                        cmd.emit_step = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_final = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/sslew_datapath.sv @@
module sslew_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     enable_we,
    input  logic                     enable_wdata,
    input  logic                     s_tuser,
    input  logic [7:0]               s_tdata,
    input  sslew_pkg::sslew_cmd_t    cmd,
    output sslew_pkg::sslew_status_t status,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic                     m_tuser,
    output logic                     m_tlast,
    output logic [31:0]              m_tdata
);
    import sslew_pkg::*;

    logic       enable_reg;
    logic [7:0] head_pos_reg;
    logic [7:0] hand_pos_reg;
    logic       sel_reg;
    logic [7:0] tgt_reg;
    logic [7:0] p_reg;
    logic       up_reg;
    logic       move_reg;

    logic        out_valid_reg;
    logic        out_id_reg;
    logic [7:0]  out_angle_reg;
    logic [11:0] out_pulse_reg;
    logic        out_last_reg;
    logic [7:0]  out_rep_reg;

    logic [7:0]  head_tgt;
    logic [7:0]  req_sat;
    logic [7:0]  req_rev;
    logic [7:0]  hand_tgt;
    logic [7:0]  tgt_in;
    logic [7:0]  cur_in;
    logic [7:0]  emit_angle;
    logic [27:0] pulse_prod;
    logic [11:0] pulse_val;
    logic        slot_free;

    // target clamping per servo
    always_comb
    begin
        if (s_tdata < HEAD_MIN)
            head_tgt = HEAD_MIN;
        else if (s_tdata > HEAD_MAX)
            head_tgt = HEAD_MAX;
        else
            head_tgt = s_tdata;

        req_sat = (s_tdata > ANGLE_MAX) ? ANGLE_MAX : s_tdata;
        req_rev = ANGLE_MAX - req_sat;
        if (req_rev < HAND_MIN)
            hand_tgt = HAND_MIN;
        else if (req_rev > HAND_MAX)
            hand_tgt = HAND_MAX;
        else
            hand_tgt = req_rev;

        tgt_in = (s_tuser == SERVO_HAND) ? hand_tgt : head_tgt;
        cur_in = (s_tuser == SERVO_HAND) ? hand_pos_reg : head_pos_reg;
    end

    // pulse width of the angle being emitted
    assign emit_angle = cmd.emit_final ? tgt_reg : p_reg;
    assign pulse_prod = {20'd0, emit_angle} * {8'd0, PULSE_RECIP};
    assign pulse_val  = PULSE_BASE + pulse_prod[27:16];

    assign slot_free = !out_valid_reg || m_tready;

    assign status.enable    = enable_reg;
    assign status.slot_free = slot_free;
    assign status.ramp_more = move_reg &&
                              (up_reg ? (p_reg <= tgt_reg) : (p_reg >= tgt_reg));

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_id_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_rep_reg, out_pulse_reg, out_angle_reg};

    // control and servo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            head_pos_reg  <= POS_RESET;
            hand_pos_reg  <= POS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (enable_we)
                enable_reg <= enable_wdata;
            if (cmd.emit_final)
            begin
                if (sel_reg == SERVO_HAND)
                    hand_pos_reg <= tgt_reg;
                else
                    head_pos_reg <= tgt_reg;
            end
            if (cmd.emit_step || cmd.emit_final)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // request and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sel_reg  <= s_tuser;
            tgt_reg  <= tgt_in;
            p_reg    <= cur_in;
            up_reg   <= (cur_in < tgt_in);
            move_reg <= (cur_in != tgt_in);
        end
        else if (cmd.emit_step)
        begin
            p_reg <= up_reg ? (p_reg + RAMP_STEP) : (p_reg - RAMP_STEP);
        end

        if (cmd.emit_step || cmd.emit_final)
        begin
            out_id_reg    <= sel_reg;
            out_angle_reg <= emit_angle;
            out_pulse_reg <= pulse_val;
            out_last_reg  <= cmd.emit_final;
            if (!cmd.emit_final)
                out_rep_reg <= 8'd0;
            else if (sel_reg == SERVO_HAND)
                out_rep_reg <= ANGLE_MAX - tgt_reg;
            else
                out_rep_reg <= tgt_reg;
        end
    end

endmodule

@@ rtl/servo_slew_ramp_generator_top.sv @@
// servo slew ramp generator for two servos, head (tuser 0) and hand (tuser 1).
// each request item carries a target angle; the head target is clamped to
// 60..110, the hand target is saturated at 180, reversed to 180 minus angle and
// clamped to 90..133. the block then streams set-points from the servo's current
// angle towards the target in steps of 2 (the current angle first), followed by
// the exact target marked with tlast, which also becomes the new current angle.
// every set-point carries its pulse width, 500 + angle*2000/180 us truncated.
// the tlast item also reports the position (head angle, or 180 minus hand angle).
// while enable is low, requests are taken and dropped. one request at a time:
// a request with a ramp of n set-points takes n + 1 output items at one item per
// cycle when the sink is ready, after a capture step; the single output register,
// paced by m_tready, sets that pace. the next request is taken as soon as the
// tlast item sits in the output register.
module servo_slew_ramp_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: enable register
    input  logic        enable_we,
    input  logic        enable_wdata,
    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] servo_select
    input  logic [7:0]  s_tdata,   // [7:0] target_angle
    // set-point items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // [0] servo_id
    output logic        m_tlast,   // last_step
    output logic [31:0] m_tdata    // [7:0] setpoint_angle, [19:8] pulse_width_us,
                                   // [27:20] reported_position, [31:28] zero
);
    import sslew_pkg::*;

    sslew_cmd_t    cmd;
    sslew_status_t status;

    // sequencer: capture, ramp, final target
    sslew_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // clamping, ramp counter, positions, pulse width and output register
    sslew_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable_we    (enable_we),
        .enable_wdata (enable_wdata),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .m_tdata      (m_tdata)
    );

endmodule

@@ test/servo_slew_ramp_generator_top_tb.sv @@
`timescale 1ns / 100ps

import sslew_pkg::*;

typedef struct {
    bit        servo;
    bit [7:0]  angle;
    bit [11:0] pulse_us;
    bit        last;
    bit [7:0]  position;
} setpoint_t;

class setpoint_scoreboard;

    bit          enabled;
    bit [7:0]    head_angle;
    bit [7:0]    hand_angle;
    setpoint_t   due_setpoints[$];
    int          mismatches;

    function new();
        enabled    = 1'b0;
        head_angle = POS_RESET;
        hand_angle = POS_RESET;
        mismatches = 0;
    endfunction

    function void set_enable(bit value);
        enabled = value;
    endfunction

    function int unsigned limit_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function void add_setpoint(bit servo, int unsigned angle, bit last,
                               int unsigned position);
        setpoint_t sp;
        sp.servo    = servo;
        sp.angle    = angle[7:0];
        sp.pulse_us = 12'(32'd500 + (angle * 32'd2000) / 32'd180);
        sp.last     = last;
        sp.position = position[7:0];
        due_setpoints.push_back(sp);
    endfunction

    function void note_request(bit servo, bit [7:0] request);
        int unsigned here;
        int unsigned goal;
        int unsigned p;
        int          steps;
        if (!enabled)
        begin
            return;
        end
        if (servo == SERVO_HEAD)
        begin
            goal = limit_to(request, HEAD_MIN, HEAD_MAX);
            here = head_angle;
        end
        else
        begin
            goal = limit_to(ANGLE_MAX - limit_to(request, 0, ANGLE_MAX), HAND_MIN, HAND_MAX);
            here = hand_angle;
        end
        steps = 0;
        if (here < goal)
        begin
            for (p = here; p <= goal && steps < 26; p += RAMP_STEP)
            begin
                add_setpoint(servo, p, 1'b0, 0);
                steps++;
            end
        end
        else if (here > goal)
        begin
            p = here;
            while (p >= goal && steps < 26)
            begin
                add_setpoint(servo, p, 1'b0, 0);
                steps++;
                if (p < RAMP_STEP)
                begin
                    break;
                end
                p -= RAMP_STEP;
            end
        end
        if (servo == SERVO_HEAD)
        begin
            head_angle = goal[7:0];
            add_setpoint(servo, goal, 1'b1, goal);
        end
        else
        begin
            hand_angle = goal[7:0];
            add_setpoint(servo, goal, 1'b1, ANGLE_MAX - goal);
        end
    endfunction

    function void check_setpoint(bit servo, bit last, bit [31:0] data);
        setpoint_t sp;
        if (due_setpoints.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: set-point with none due: id %0d last %0d data %h",
                         $realtime, servo, last, data);
            end
            return;
        end
        sp = due_setpoints.pop_front();
        if (servo !== sp.servo || last !== sp.last || data[7:0] !== sp.angle ||
            data[19:8] !== sp.pulse_us || data[27:20] !== sp.position ||
            data[31:28] !== 4'd0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: set-point wrong: expected id %0d angle %0d pulse %0d last %0d pos %0d",
                         $realtime, sp.servo, sp.angle, sp.pulse_us, sp.last, sp.position);
                $display("        got id %0d angle %0d pulse %0d last %0d pos %0d pad %h",
                         servo, data[7:0], data[19:8], last, data[27:20], data[31:28]);
            end
        end
    endfunction

    function int pending();
        return due_setpoints.size();
    endfunction

    function int close_out();
        if (due_setpoints.size() != 0)
        begin
            $display("%0d set-points never arrived", due_setpoints.size());
        end
        return mismatches + due_setpoints.size();
    endfunction

endclass

module servo_slew_ramp_generator_top_tb;

    // enough cycles for the block to finish any ramp still in flight
    localparam int SETTLE_CYCLES = 40;
    // run limit, well above the slowest correct run with full stalls
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 105;

    // directed requests: {servo, target angle}
    localparam bit [8:0] DIRECTED [18] = '{
        {SERVO_HEAD, 8'd90},    // already at target, single final item
        {SERVO_HEAD, 8'd0},     // below head limit, even distance downwards
        {SERVO_HEAD, 8'd255},   // above head limit, longest ramp
        {SERVO_HEAD, 8'd110},   // already at upper limit
        {SERVO_HEAD, 8'd75},    // odd distance downwards
        {SERVO_HEAD, 8'd61},
        {SERVO_HEAD, 8'd109},   // even distance upwards
        {SERVO_HEAD, 8'd60},
        {SERVO_HAND, 8'd90},    // reversed to 90, already there
        {SERVO_HAND, 8'd0},     // reversed to 180, clamped to 133
        {SERVO_HAND, 8'd255},   // saturates to 180, reversed to 0, clamped to 90
        {SERVO_HAND, 8'd47},    // exactly the upper hand limit
        {SERVO_HAND, 8'd46},
        {SERVO_HAND, 8'd181},
        {SERVO_HAND, 8'd89},    // odd distance
        {SERVO_HAND, 8'd70},
        {SERVO_HAND, 8'd180},
        {SERVO_HAND, 8'd128}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        enable_we = 1'b0;
    logic        enable_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tuser;
    logic        m_tlast;
    logic [31:0] m_tdata;

    // chance in a hundred that the request side idles / the sink stalls
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int          cycle_count = 0;

    setpoint_scoreboard sb = new();

    servo_slew_ramp_generator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable_we    (enable_we),
        .enable_wdata (enable_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),    // [0] servo_select
        .s_tdata      (s_tdata),    // [7:0] target_angle
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),    // [0] servo_id
        .m_tlast      (m_tlast),    // last_step
        .m_tdata      (m_tdata)     // [7:0] angle, [19:8] pulse, [27:20] position
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sink side: ready is redrawn on every falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: everything is sampled on the rising edge; register writes and
    // requests never share an edge, and a request's set-points come later
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (enable_we)
            begin
                sb.set_enable(enable_wdata);
            end
            if (s_tvalid && s_tready)
            begin
                sb.note_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_setpoint(m_tuser, m_tlast, m_tdata);
            end
        end
    end

    // offer one request and hold it until taken; entered and left on a falling
    // edge so that valid is assigned once per edge
    task automatic send_request(input bit servo, input bit [7:0] request);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= servo;
        s_tdata  <= request;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    // random request, weighted towards the clamp regions of each servo
    task automatic send_random_request();
        bit       servo;
        bit [7:0] request;
        servo = 1'($urandom_range(1, 0));
        case ($urandom_range(3))
            0: request = 8'($urandom_range(255));
            1: request = 8'($urandom_range(120, 50));
            2: request = 8'($urandom_range(100, 40));
            default:
            begin
                case ($urandom_range(7))
                    0: request = 8'd0;
                    1: request = 8'd60;
                    2: request = 8'd110;
                    3: request = 8'd180;
                    4: request = 8'd255;
                    5: request = 8'd47;
                    6: request = 8'd90;
                    default: request = 8'd181;
                endcase
            end
        endcase
        send_request(servo, request);
    endtask

    // let every due set-point arrive, then give the block time to go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_enable(input bit value);
        enable_we    <= 1'b1;
        enable_wdata <= value;
        @(negedge clk);
        enable_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        // reset is held from time zero and released away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // enable is low out of reset: these requests must be dropped
        for (int i = 0; i < 4; i++)
        begin
            send_random_request();
        end
        drain();

        write_enable(1'b1);
        foreach (DIRECTED[i])
        begin
            send_request(DIRECTED[i][8], DIRECTED[i][7:0]);
        end
        drain();

        // random phases: no idling, idle source, stalling sink, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 66;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 66;
                end
                default:
                begin
                    src_idle_pct   = 38;
                    sink_stall_pct = 38;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random_request();
            end
            drain();

            // switch off, throw a few requests at it, switch back on
            write_enable(1'b0);
            for (int i = 0; i < 3; i++)
            begin
                send_random_request();
            end
            drain();
            write_enable(1'b1);
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.close_out() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
